// ===== hdl/crc15_register_group_checker_assert.svh =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC15_REGISTER_GROUP_CHECKER_ASSERT_SVH
`define CRC15_REGISTER_GROUP_CHECKER_ASSERT_SVH

// Same-cycle implication
`define CRC15GC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CRC15GC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/crc15gc_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker: package
// Shared types, register indexes, reset values and scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package crc15gc_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_SEED       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_POLYNOMIAL = 2'd2;

	localparam int CFG_DATA_W = 15;

	// Reset values
	localparam logic [4:0]  RST_CHAIN_LENGTH     = 5'd2;
	localparam logic [14:0] RST_CHECK_SEED       = 15'd16;
	localparam logic [14:0] RST_CHECK_POLYNOMIAL = 15'h4599;

	// Chain and queue sizing
	localparam int MAX_CHAIN_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Byte positions within one chip group
	localparam logic [2:0] POS_FIRST_CHECK = 3'd6;
	localparam logic [2:0] POS_LAST        = 3'd7;

	// Division by ten as multiply by reciprocal, exact for 16-bit inputs
	localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
	localparam int          DIV10_SHIFT = 19;
	localparam int          SCALED_W    = 13;

	// One finished chip group, handed from the front end to the back end
	typedef struct packed {
		logic [3:0]  chip_index;
		logic [2:0]  group_echo;
		logic [15:0] code_first;
		logic [15:0] code_second;
		logic [15:0] code_third;
		logic [15:0] received_check;
		logic        check_ok;
		logic        error_so_far;
		logic        last_of_read;
	} grp_rec_t;

endpackage

`default_nettype wire

// ===== hdl/crc15gc_fifo.sv =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker: group queue
// Small flop-based FIFO between the byte front end and the scaling back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc15_register_group_checker_assert.svh"

module crc15gc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CRC15GC_ASSERT_NOW(a_no_push_full, push, !full, "group pushed into full queue")
	`CRC15GC_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "group popped from empty queue")
	`CRC15GC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "queue count overrun")

endmodule

`default_nettype wire

// ===== hdl/crc15gc_front.sv =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker: front end
// Accepts bytes, runs the CRC-15, collects each chip group and classifies it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc15_register_group_checker_assert.svh"

module crc15gc_front #(
	parameter int MAX_CHAIN = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	input  wire logic [crc15gc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [crc15gc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [7:0]                             rx_byte,
	input  wire logic                                   start_of_read,
	input  wire logic [2:0]                             group_id,
	output logic                                        push,
	output crc15gc_pkg::grp_rec_t                       rec,
	input  wire logic                                   queue_full
);

	import crc15gc_pkg::*;

	localparam logic [4:0] MAX_LEN = 5'(MAX_CHAIN);

	logic [4:0]  chain_q;
	logic [14:0] seed_q;
	logic [14:0] poly_q;

	logic [15:0] rem_q;
	logic [2:0]  pos_q;
	logic [3:0]  chip_q;
	logic        err_q;
	logic [2:0]  grp_q;
	logic [7:0]  bytes_q [7];

	logic [15:0] rem_e;
	logic [2:0]  pos_e;
	logic [3:0]  chip_e;
	logic        err_e;
	logic [2:0]  grp_e;
	logic [4:0]  len_e;
	logic        accept;
	logic        is_check;

	// One table entry formed from the polynomial, then the byte-wide update
	function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] b,
		input logic [14:0] poly);
		logic [15:0] r;
		r = {1'b0, rem[14:7] ^ b, 7'd0};
		for (int k = 0; k < 8; k++) begin
			if (r[14]) begin
				r = {r[14:0], 1'b0} ^ {1'b0, poly};
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return {rem[7:0], 8'h00} ^ r;
	endfunction

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Start of read clears the group context before the byte is taken
	always_comb begin
		rem_e  = start_of_read ? {1'b0, seed_q} : rem_q;
		pos_e  = start_of_read ? '0 : pos_q;
		chip_e = start_of_read ? '0 : chip_q;
		err_e  = start_of_read ? 1'b0 : err_q;
		grp_e  = start_of_read ? group_id : grp_q;
	end

	always_comb begin
		if (chain_q == '0) begin
			len_e = 5'd1;
		end else if (chain_q > MAX_LEN) begin
			len_e = MAX_LEN;
		end else begin
			len_e = chain_q;
		end
	end

	assign is_check = (pos_e == POS_LAST);
	assign push     = accept && is_check;

	always_comb begin
		rec.chip_index     = chip_e;
		rec.group_echo     = grp_e;
		rec.code_first     = {bytes_q[1], bytes_q[0]};
		rec.code_second    = {bytes_q[3], bytes_q[2]};
		rec.code_third     = {bytes_q[5], bytes_q[4]};
		rec.received_check = {bytes_q[6], rx_byte};
		rec.check_ok       = (rec.received_check == {rem_e[14:0], 1'b0});
		rec.error_so_far   = err_e || !rec.check_ok;
		rec.last_of_read   = ({1'b0, chip_e} == (len_e - 5'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= RST_CHAIN_LENGTH;
			seed_q  <= RST_CHECK_SEED;
			poly_q  <= RST_CHECK_POLYNOMIAL;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHAIN_LENGTH:     chain_q <= cfg_data[4:0];
				REG_CHECK_SEED:       seed_q  <= cfg_data;
				REG_CHECK_POLYNOMIAL: poly_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= {1'b0, RST_CHECK_SEED};
			pos_q  <= '0;
			chip_q <= '0;
			err_q  <= 1'b0;
			grp_q  <= '0;
		end else if (accept) begin
			grp_q <= grp_e;
			if (!is_check) begin
				if (pos_e < POS_FIRST_CHECK) begin
					rem_q <= crc_byte(rem_e, rx_byte, poly_q);
				end else begin
					rem_q <= rem_e;
				end
				pos_q  <= pos_e + 3'd1;
				chip_q <= chip_e;
				err_q  <= err_e;
			end else begin
				// Close the group: reload the seed, advance the chip or wrap it after the last
				rem_q  <= {1'b0, seed_q};
				pos_q  <= '0;
				chip_q <= rec.last_of_read ? '0 : chip_e + 4'd1;
				err_q  <= rec.error_so_far;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_check) begin
			bytes_q[pos_e] <= rx_byte;
		end
	end

	`CRC15GC_ASSERT_NEXT(a_pos_wrap, push, pos_q == '0, "byte position not cleared after group")
	`CRC15GC_ASSERT_NEXT(a_chip_wrap, push && rec.last_of_read, chip_q == '0,
		"chip counter not cleared after last chip")

endmodule

`default_nettype wire

// ===== hdl/crc15gc_back.sv =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker: back end
// Scales the three codes by one tenth and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "crc15_register_group_checker_assert.svh"

module crc15gc_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  q_valid,
	output logic                                       pop,
	input  wire crc15gc_pkg::grp_rec_t                 q_rec,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output crc15gc_pkg::grp_rec_t                      res,
	output logic [crc15gc_pkg::SCALED_W-1:0]           scaled_first,
	output logic [crc15gc_pkg::SCALED_W-1:0]           scaled_second,
	output logic [crc15gc_pkg::SCALED_W-1:0]           scaled_third
);

	import crc15gc_pkg::*;

	grp_rec_t              rec_s1;
	logic [31:0]           prod0_s1;
	logic [31:0]           prod1_s1;
	logic [31:0]           prod2_s1;
	logic                  valid_s1;
	grp_rec_t              rec_s2;
	logic [SCALED_W-1:0]   sc0_s2;
	logic [SCALED_W-1:0]   sc1_s2;
	logic [SCALED_W-1:0]   sc2_s2;
	logic                  valid_s2;
	logic                  adv_s1;
	logic                  adv_s2;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = q_valid && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_s1   <= q_rec;
			prod0_s1 <= {16'd0, q_rec.code_first} * {16'd0, DIV10_MUL};
			prod1_s1 <= {16'd0, q_rec.code_second} * {16'd0, DIV10_MUL};
			prod2_s1 <= {16'd0, q_rec.code_third} * {16'd0, DIV10_MUL};
		end
		if (adv_s2 && valid_s1) begin
			rec_s2 <= rec_s1;
			sc0_s2 <= prod0_s1[DIV10_SHIFT +: SCALED_W];
			sc1_s2 <= prod1_s1[DIV10_SHIFT +: SCALED_W];
			sc2_s2 <= prod2_s1[DIV10_SHIFT +: SCALED_W];
		end
	end

	assign out_valid     = valid_s2;
	assign res           = rec_s2;
	assign scaled_first  = sc0_s2;
	assign scaled_second = sc1_s2;
	assign scaled_third  = sc2_s2;

	`CRC15GC_ASSERT_NOW(a_scale_first, out_valid,
		(20'(sc0_s2) * 20'd10 <= 20'(rec_s2.code_first)) &&
		(20'(rec_s2.code_first) - 20'(sc0_s2) * 20'd10 < 20'd10),
		"first code scaled wrongly")

endmodule

`default_nettype wire

// ===== hdl/crc15_register_group_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-15 register group checker
// Checks the CRC-15 of each chip's group in a daisy-chain read-back stream.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  in      | in_valid / in_ready     | rx_byte, start_of_read, group_id
//  out     | out_valid / out_ready   | chip_index .. last_of_read
//
//  One byte a cycle while in_ready is high; the CRC update and group assembly keep pace with each accepted byte.
//  A chip's result passes the queue, the product register and the output
//  register after its eighth byte; cfg_ready is always high.
//  Reset loads chain length 2, seed 16 and polynomial 0x4599; no clearing pass.
//  in_ready drops whenever the group queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module crc15_register_group_checker #(
	parameter int MAX_CHAIN   = crc15gc_pkg::MAX_CHAIN_DEF,
	parameter int QUEUE_DEPTH = crc15gc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [crc15gc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [crc15gc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          rx_byte,
	input  wire logic                                start_of_read,
	input  wire logic [2:0]                          group_id,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [3:0]                               chip_index,
	output logic [2:0]                               group_echo,
	output logic [15:0]                              code_first,
	output logic [15:0]                              code_second,
	output logic [15:0]                              code_third,
	output logic [12:0]                              scaled_first,
	output logic [12:0]                              scaled_second,
	output logic [12:0]                              scaled_third,
	output logic [15:0]                              received_check,
	output logic                                     check_ok,
	output logic                                     error_so_far,
	output logic                                     last_of_read
);

	import crc15gc_pkg::*;

	localparam int REC_W = $bits(grp_rec_t);

	grp_rec_t    front_rec;
	grp_rec_t    queue_rec;
	grp_rec_t    res;
	logic [REC_W-1:0] queue_data;
	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_valid;

	assign cfg_ready = 1'b1;

	crc15gc_front #(
		.MAX_CHAIN (MAX_CHAIN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.start_of_read (start_of_read),
		.group_id      (group_id),
		.push          (push),
		.rec           (front_rec),
		.queue_full    (queue_full)
	);

	crc15gc_fifo #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (front_rec),
		.full      (queue_full),
		.pop       (pop),
		.rd_data   (queue_data),
		.not_empty (queue_valid)
	);

	assign queue_rec = grp_rec_t'(queue_data);

	crc15gc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (queue_valid),
		.pop           (pop),
		.q_rec         (queue_rec),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.res           (res),
		.scaled_first  (scaled_first),
		.scaled_second (scaled_second),
		.scaled_third  (scaled_third)
	);

	assign chip_index     = res.chip_index;
	assign group_echo     = res.group_echo;
	assign code_first     = res.code_first;
	assign code_second    = res.code_second;
	assign code_third     = res.code_third;
	assign received_check = res.received_check;
	assign check_ok       = res.check_ok;
	assign error_so_far   = res.error_so_far;
	assign last_of_read   = res.last_of_read;

endmodule

`default_nettype wire
